/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the line encoder.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/ule_pkg.sv */
// Package for the uuencode line encoder: job type, queue status, constants
// and the 6-bit to character mapping. Depends on nothing.
`timescale 1ns / 1ps

package ule_pkg;

    localparam int LINE_CAP_DEF    = 45;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] CHAR_ZERO = 7'h60;  // stands for a zero value
    localparam logic [6:0] CHAR_BIAS = 7'h20;
    localparam int         JOB_CHARS = 5;      // length char plus four group chars

    // One decoded item: which characters to emit and what goes into them.
    typedef struct packed {
        logic [JOB_CHARS-1:0] mask;      // bit 0: length char, bits 4:1: group chars
        logic [6:0]           len_char;
        logic [23:0]          grp;       // three bytes, first byte in 23:16
        logic                 line_end;  // mark the final char of this job
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [6:0] uu_char(input logic [5:0] v);
        logic [6:0] ch;
        ch = (v == 6'd0) ? CHAR_ZERO : ({1'b0, v} + CHAR_BIAS);
        return ch;
    endfunction

endpackage

/* rtl/uu_line_encoder_unit.sv */
// uuencode line encoder: top level joining front end, job queue and emitter.
// Depends on ule_pkg, ule_front, ule_queue, ule_back and assert_macros.svh.
`timescale 1ns / 1ps

// Encodes one line of bytes into uuencode characters, one character per
// output transaction. An item is taken whenever the job queue
// (QUEUE_DEPTH entries) has room; it yields 0 to 5 characters: the length
// character on line start, four characters per completed or flushed group.
// The emitter drives one character per cycle through the output register
// while the receiver is ready. An item passes through the job queue and the
// emitter's job registers before its first character reaches the output
// register. last_char marks the final character of the line-end item.

`include "assert_macros.svh"

module uu_line_encoder_unit
    import ule_pkg::*;
#(
    parameter int LINE_CAP    = LINE_CAP_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_line_start,
    input  logic [5:0] i_line_bytes,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);

    t_job    job, head;
    t_q_stat q_stat;
    logic    accept, push, pop;
    logic    char_ok;

    assign o_ready = !q_stat.full;
    assign accept  = i_valid && o_ready;
    assign char_ok = (o_out_char >= CHAR_BIAS) && (o_out_char <= CHAR_ZERO);

    ule_front #(
        .LINE_CAP(LINE_CAP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_byte_valid(i_byte_valid),
        .i_line_start(i_line_start),
        .i_line_bytes(i_line_bytes),
        .i_line_end  (i_line_end),
        .o_job       (job),
        .o_push_req  (push)
    );

    ule_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (q_stat)
    );

    ule_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_last_char(o_last_char)
    );

    // a popped job loads the emitter's job registers first, its first character then goes through the output register
    `ASSERT_IMPLY(a_char_range, i_clk, i_rst_n, o_valid, char_ok)
    `ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, push, !q_stat.full)
    `ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, pop, !q_stat.empty)
    `ASSERT_NEXT(a_job_reaches_out, i_clk, i_rst_n, pop, ##1 o_valid)

endmodule

/* rtl/ule_front.sv */
// Front end: takes input items, tracks the pending byte group and builds jobs.
// Depends on ule_pkg.
`timescale 1ns / 1ps

module ule_front
    import ule_pkg::*;
#(
    parameter int LINE_CAP = LINE_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_line_start,
    input  logic [5:0] i_line_bytes,
    input  logic       i_line_end,
    output t_job       o_job,
    output logic       o_push_req
);

    logic [7:0] r_hi, r_lo;
    logic [1:0] r_fill;
    logic [7:0] n_hi, n_lo;
    logic [1:0] n_fill;

    logic [1:0] fill_in;
    logic [1:0] fill_mid;
    logic       grp_full;
    logic       flush;
    logic [5:0] nbytes;
    logic [23:0] grp;

    always_comb begin
        fill_in  = i_line_start ? 2'd0 : r_fill;
        n_hi     = r_hi;
        n_lo     = r_lo;
        fill_mid = fill_in;
        grp_full = 1'b0;
        grp      = '0;
        if (i_byte_valid) begin
            case (fill_in)
                2'd0: begin
                    n_hi     = i_data_byte;
                    fill_mid = 2'd1;
                end
                2'd1: begin
                    n_lo     = i_data_byte;
                    fill_mid = 2'd2;
                end
                default: begin
                    grp      = {r_hi, r_lo, i_data_byte};
                    grp_full = 1'b1;
                    fill_mid = 2'd0;
                end
            endcase
        end
        // line end pads a partial group with zero bytes
        flush = i_line_end && (fill_mid != 2'd0);
        if (flush) begin
            grp = {n_hi, (fill_mid == 2'd2) ? n_lo : 8'h00, 8'h00};
        end
        n_fill = i_line_end ? 2'd0 : fill_mid;
    end

    always_comb begin
        nbytes = (i_line_bytes > 6'(LINE_CAP)) ? 6'(LINE_CAP) : i_line_bytes;
        o_job.len_char = (nbytes == 6'd0) ? CHAR_ZERO : ({1'b0, nbytes} + CHAR_BIAS);
        o_job.mask     = {{(JOB_CHARS-1){grp_full || flush}}, i_line_start};
        o_job.grp      = grp;
        o_job.line_end = i_line_end;
        o_push_req     = i_accept && (o_job.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

endmodule

/* rtl/ule_queue.sv */
// Short job queue between front end and character emitter.
// Depends on ule_pkg.
`timescale 1ns / 1ps

module ule_queue
    import ule_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr, n_rd;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

/* rtl/ule_back.sv */
// Back end: walks the characters of one job and drives the output register.
// Depends on ule_pkg.
`timescale 1ns / 1ps

module ule_back
    import ule_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);

    logic [JOB_CHARS-1:0] r_rem;
    logic [JOB_CHARS-1:0] n_rem;
    logic [6:0]           r_len_char;
    logic [23:0]          r_grp;
    logic                 r_line_end;
    logic                 r_valid;
    logic [6:0]           r_char;
    logic                 r_last;

    logic                 busy, load, emit, take;
    logic [JOB_CHARS-1:0] rem_after, pick;
    logic [6:0]           cur_char;

    always_comb begin
        busy      = (r_rem != '0);
        load      = !r_valid || i_ready;
        emit      = busy && load;
        rem_after = r_rem & (r_rem - 1'b1);
        pick      = r_rem & ~rem_after;   // lowest pending character
        take      = !busy || (emit && (rem_after == '0));
        o_pop     = take && !i_q_stat.empty;

        cur_char = r_len_char;
        if (pick[1]) cur_char = uu_char(r_grp[23:18]);
        if (pick[2]) cur_char = uu_char(r_grp[17:12]);
        if (pick[3]) cur_char = uu_char(r_grp[11:6]);
        if (pick[4]) cur_char = uu_char(r_grp[5:0]);

        if (o_pop) begin
            n_rem = i_head.mask;
        end else if (emit) begin
            n_rem = rem_after;
        end else begin
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rem <= n_rem;
            if (load) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_len_char <= i_head.len_char;
            r_grp      <= i_head.grp;
            r_line_end <= i_head.line_end;
        end
        if (emit) begin
            r_char <= cur_char;
            r_last <= r_line_end && (rem_after == '0);
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule
